FILE: design/itda_pkg.sv
// Package for the decimal ASCII converter: word types, control struct and
// character codes. It depends on nothing else.
`timescale 1ns / 1ps

package itda_pkg;

   typedef struct packed {
      logic [31:0] value_bits;
      logic        signed_mode;
   } req_word_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic shift;
   } itda_ctrl_type;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

endpackage

FILE: design/itda_dabble.sv
// Bit-serial double dabble datapath: a magnitude shift register feeding a BCD
// shift register, one bit per conversion cycle and one digit per emit cycle in which shift is set.
// It depends on itda_pkg for the control struct.
`timescale 1ns / 1ps

module itda_dabble #(
   parameter int WIDTH = 32,
   parameter int NDIG  = 10
) (
   input  logic                  clock,
   input  itda_pkg::itda_ctrl_type ctrl,
   input  logic [WIDTH-1:0]      load_mag,
   output logic [3:0]            top_digit
);
   import itda_pkg::*;

   localparam int BCD_W = NDIG * 4;

   logic [WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [BCD_W-1:0] adj;

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         mag_in = load_mag;
         bcd_in = '0;
      end else if (ctrl.dabble) begin
         bcd_in = {adj[BCD_W-2:0], mag_ff[WIDTH-1]};
         mag_in = {mag_ff[WIDTH-2:0], 1'b0};
      end else if (ctrl.shift) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

FILE: design/int_to_decimal_ascii.sv
// Top level of the decimal ASCII converter: handshakes, sequencer and output
// register. It depends on itda_pkg and instantiates itda_dabble.
`timescale 1ns / 1ps

// Converts one WIDTH-bit word per request into its decimal spelling, one
// character per response word, most significant digit first, with a leading
// minus for negative values in signed mode and the last character flagged.
// A word is taken, converted by bit-serial double dabble, then spelled one
// digit position at a time (leading zeros are skipped at one position per
// cycle), after a minus sign if there is one; a character is held back while
// the response side stalls. The next request is taken once the last character
// sits in the output register.
module int_to_decimal_ascii #(
   parameter int WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  itda_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output itda_pkg::rsp_word_type rsp_word
);
   import itda_pkg::*;

   localparam int NDIG   = ((WIDTH * 1233) >> 12) + 1;
   localparam int CNT_W  = $clog2(WIDTH + 1);
   localparam int DCNT_W = $clog2(NDIG + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [DCNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic             sign_ff, sign_in;
   logic             seen_ff, seen_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   itda_ctrl_type    ctrl;
   logic [WIDTH-1:0] raw;
   logic [WIDTH-1:0] load_mag;
   logic             neg;
   logic [3:0]       top_digit;
   logic             out_free;
   logic             accept;

   assign raw      = req_word.value_bits[WIDTH-1:0];
   assign neg      = req_word.signed_mode & raw[WIDTH-1];
   assign load_mag = neg ? (~raw + {{(WIDTH-1){1'b0}}, 1'b1}) : raw;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept   = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      sign_in      = sign_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      ctrl         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.load  = 1'b1;
               sign_in    = neg;
               seen_in    = 1'b0;
               bit_cnt_in = CNT_W'(WIDTH);
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            ctrl.dabble = 1'b1;
            bit_cnt_in  = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == CNT_W'(1)) begin
               dig_cnt_in = DCNT_W'(NDIG);
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!seen_ff && !sign_ff && top_digit == 4'd0 && dig_cnt_ff != DCNT_W'(1)) begin
               ctrl.shift = 1'b1;
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_word_in.character = CHAR_MINUS;
                  rsp_word_in.last_char = 1'b0;
                  sign_in               = 1'b0;
               end else begin
                  rsp_word_in.character = CHAR_ZERO + {4'd0, top_digit};
                  rsp_word_in.last_char = (dig_cnt_ff == DCNT_W'(1));
                  ctrl.shift            = 1'b1;
                  seen_in               = 1'b1;
                  dig_cnt_in            = dig_cnt_ff - 1'b1;
                  if (dig_cnt_ff == DCNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sign_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bit_cnt_ff   <= '0;
         dig_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         sign_ff      <= sign_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_cnt_ff   <= bit_cnt_in;
         dig_cnt_ff   <= dig_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   itda_dabble #(
      .WIDTH (WIDTH),
      .NDIG  (NDIG)
   ) u_dabble (
      .clock     (clock),
      .ctrl      (ctrl),
      .load_mag  (load_mag),
      .top_digit (top_digit)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTH
   a_accept_starts_conv : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CONV)
      else $error("Accepted word did not start a conversion.");

   a_mid_word_in_emit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.last_char |-> state_ff == ST_EMIT)
      else $error("Non-final character pending outside the emit phase.");

   a_no_sign_when_idle : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !sign_ff)
      else $error("Minus sign left pending while idle.");

   a_digit_when_counted : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> dig_cnt_ff != '0)
      else $error("Emit phase with no digit positions left.");
`endif

endmodule

FILE: tb/sv/tb.sv
// Testbench for int_to_decimal_ascii: drives numbers and checks every
// character word against its own decimal spelling of each accepted number.
// It depends on itda_pkg and the int_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module tb;

   import itda_pkg::*;

   localparam int WIDTH       = 32;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 60;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   req_word_type req_word    = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   rsp_word_type rsp_word;

   logic         steady      = 1'b0;
   logic         hold_wanted = 1'b0;
   int           mismatch_count = 0;
   rsp_word_type pending_chars[$];

   int_to_decimal_ascii #(.WIDTH(WIDTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < 100) begin
         $display("tb: mismatch in %s at %0t: got %0d, expected %0d", what, $realtime,
                  got, want);
      end
      mismatch_count++;
   endtask

   // Queues the characters that one accepted number must produce.
   task automatic spell_decimal(input req_word_type w);
      logic [WIDTH-1:0] raw;
      logic             negative;
      logic [WIDTH:0]   magnitude;
      logic [3:0]       digits[10];
      int               count;
      rsp_word_type     c;
      raw = w.value_bits[WIDTH-1:0];
      negative = w.signed_mode && raw[WIDTH-1];
      magnitude = negative ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};
      count = 0;
      if (magnitude == 0) begin
         digits[0] = 4'd0;
         count = 1;
      end
      while (magnitude != 0 && count < 10) begin
         digits[count] = 4'(magnitude % 10);
         magnitude = magnitude / 10;
         count++;
      end
      if (negative) begin
         c.character = CHAR_MINUS;
         c.last_char = 1'b0;
         pending_chars.push_back(c);
      end
      for (int k = count - 1; k >= 0; k--) begin
         c.character = CHAR_ZERO + 8'(digits[k]);
         c.last_char = (k == 0);
         pending_chars.push_back(c);
      end
   endtask

   task automatic send_word(input logic [31:0] value, input logic signed_mode);
      int gap;
      gap = 0;
      while (!steady && $urandom_range(99) < 36) begin
         gap++;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_word.value_bits = value;
      req_word.signed_mode = signed_mode;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      spell_decimal(req_word);
   endtask

   task automatic release_input();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_chars.size() > 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      logic [31:0] span;
      logic [31:0] value;
      span = 1;
      repeat ($urandom_range(1, 9)) span = span * 10;
      case ($urandom_range(3))
         0: value = $urandom();
         1: value = $urandom_range(span);
         2: value = 32'd0 - $urandom_range(span);
         default: value = span - 1 + $urandom_range(1);
      endcase
      return value;
   endfunction

   task automatic test_directed();
      send_word(32'd0, 1'b0);
      send_word(32'd0, 1'b1);
      send_word(32'd1, 1'b0);
      send_word(32'd9, 1'b1);
      send_word(32'd10, 1'b0);
      send_word(32'd99, 1'b1);
      send_word(32'd100, 1'b0);
      send_word(32'd999_999_999, 1'b0);
      send_word(32'd1_000_000_000, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h8000_0000, 1'b1);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h7FFF_FFFF, 1'b1);
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFF6, 1'b1);
      send_word(32'hAAAA_AAAA, 1'b1);
      send_word(32'h5555_5555, 1'b0);
      release_input();
      wait_drained();
   endtask

   task automatic test_random_numbers(input int count);
      repeat (count) send_word(pick_value(), 1'($urandom_range(1)));
      release_input();
      wait_drained();
   endtask

   task automatic test_steady_stream(input int count);
      steady = 1'b1;
      repeat (count) send_word(pick_value(), 1'($urandom_range(1)));
      release_input();
      wait_drained();
      steady = 1'b0;
   endtask

   task automatic test_back_pressure(input int count);
      hold_wanted = 1'b1;
      steady = 1'b1;
      repeat (count) send_word(pick_value(), 1'($urandom_range(1)));
      steady = 1'b0;
      release_input();
      wait_drained();
   endtask

   task automatic test_drained_pauses(input int rounds);
      repeat (rounds) begin
         repeat ($urandom_range(1, 4)) send_word(pick_value(), 1'($urandom_range(1)));
         release_input();
         wait_drained();
      end
   endtask

   initial begin : receiver
      logic hold_taken;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (steady) begin
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = ($urandom_range(99) < 36);
         end
      end
   end

   always @(posedge clock) begin : check_chars
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            report_mismatch("unexpected character", rsp_word.character, 0);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_word.character !== want.character) begin
               report_mismatch("character", rsp_word.character, want.character);
            end
            if (rsp_word.last_char !== want.last_char) begin
               report_mismatch("last_char", rsp_word.last_char, want.last_char);
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_numbers(200);
      test_steady_stream(40);
      test_back_pressure(20);
      test_drained_pauses(12);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
